// ===== sv/swtb_pkg.sv =====
// Shared types, codes and constants of the software timer bank.
`timescale 1ns / 1ps

package swtb_pkg;

  // Default number of timers in the bank.
  localparam int NUM_TIMERS_DEF = 16;

  // Width of the ticks-per-millisecond register and its reset value.
  localparam int TPM_W = 10;
  localparam logic [TPM_W-1:0] TPM_RESET = 10'd1;

  // Time unit codes and the matching scale factors.
  localparam logic [1:0] UNIT_SEC = 2'd1;
  localparam logic [1:0] UNIT_MIN = 2'd2;
  localparam logic [15:0] SCALE_MS  = 16'd1;
  localparam logic [15:0] SCALE_SEC = 16'd1000;
  localparam logic [15:0] SCALE_MIN = 16'd60000;

  // Command codes.
  typedef enum logic [3:0] {
    CMD_TICK      = 4'd0,
    CMD_SET       = 4'd1,
    CMD_START     = 4'd2,
    CMD_STOP      = 4'd3,
    CMD_PAUSE     = 4'd4,
    CMD_RESUME    = 4'd5,
    CMD_CLEAR     = 4'd6,
    CMD_CLEAR_ALL = 4'd7,
    CMD_SERVICE   = 4'd8,
    CMD_READ      = 4'd9
  } cmd_e;

  // Timer states.
  typedef enum logic [1:0] {
    TS_OFF   = 2'd0,
    TS_RUN   = 2'd1,
    TS_PAUSE = 2'd2,
    TS_DONE  = 2'd3
  } tstate_e;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_ONE,
    ST_SWEEP,
    ST_FLUSH
  } ctrl_state_e;

  // One entry of the timer memory.
  typedef struct packed {
    logic [31:0] count;
    tstate_e     st;
    logic        notify;
  } entry_t;

  // One result word.
  typedef struct packed {
    logic [3:0]  which;
    logic [31:0] remaining;
    tstate_e     status;
    logic        notify;
    logic        expired;
  } res_t;

  // Memory access controls from the controller.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_one;
    logic clr_all;
  } mem_ctl_t;

endpackage

// ===== sv/swtb_mem.sv =====
// Timer entry memory with a registered read port and per-entry valid bits.
`timescale 1ns / 1ps

module swtb_mem #(
  parameter int NUM_TIMERS = swtb_pkg::NUM_TIMERS_DEF,
  parameter int IDX_W      = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  swtb_pkg::mem_ctl_t  ctl_i,
  input  logic [IDX_W-1:0]    rd_addr_i,
  input  logic [IDX_W-1:0]    wr_addr_i,
  input  swtb_pkg::entry_t    wr_data_i,
  output swtb_pkg::entry_t    rdata_o
);

  swtb_pkg::entry_t mem_q [NUM_TIMERS];
  swtb_pkg::entry_t rdata_q;
  logic [NUM_TIMERS-1:0] vld_q;
  logic rd_vld_q;

  // Entry storage: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // Valid bits: an entry never written since its last clear reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (ctl_i.clr_all) begin
        vld_q <= '0;
      end else if (ctl_i.clr_one) begin
        vld_q[wr_addr_i] <= 1'b0;
      end else if (ctl_i.wr_en) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rdata_o = rd_vld_q ? rdata_q : '0;

endmodule

// ===== sv/swtb_scale.sv =====
// Load scaler: amount times unit scale times ticks per millisecond, in two stages.
`timescale 1ns / 1ps

module swtb_scale (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [swtb_pkg::TPM_W-1:0] cfg_wdata_i,
  input  logic                       load_i,
  input  logic [15:0]                amount_i,
  input  logic [1:0]                 unit_i,
  output logic [31:0]                scaled_o
);

  logic [swtb_pkg::TPM_W-1:0] tpm_q;
  logic [15:0] scale;
  logic [31:0] p1_d, p1_q, p2_q;

  // Ticks-per-millisecond register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpm_q <= swtb_pkg::TPM_RESET;
    end else if (cfg_we_i) begin
      tpm_q <= cfg_wdata_i;
    end
  end

  // Unit scale; an unused unit code counts as milliseconds.
  always_comb begin
    case (unit_i)
      swtb_pkg::UNIT_SEC: scale = swtb_pkg::SCALE_SEC;
      swtb_pkg::UNIT_MIN: scale = swtb_pkg::SCALE_MIN;
      default:            scale = swtb_pkg::SCALE_MS;
    endcase
  end

  assign p1_d = {16'd0, amount_i} * {16'd0, scale};

  // First product taken with the word, second product registered in the cycle after.
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      p1_q <= p1_d;
    end
    p2_q <= p1_q * {{(32 - swtb_pkg::TPM_W){1'b0}}, tpm_q};
  end

  assign scaled_o = p2_q;

endmodule

// ===== sv/swtb_ctrl.sv =====
// Command sequencer: read-modify-write of timer entries, sweeps and result staging.
`timescale 1ns / 1ps

module swtb_ctrl #(
  parameter int NUM_TIMERS = swtb_pkg::NUM_TIMERS_DEF,
  parameter int IDX_W      = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [3:0]         in_cmd_i,
  input  logic [3:0]         in_idx_i,
  input  logic               in_hh_i,
  input  logic [31:0]        scaled_i,
  output logic               load_o,
  output swtb_pkg::mem_ctl_t mem_ctl_o,
  output logic [IDX_W-1:0]   rd_addr_o,
  output logic [IDX_W-1:0]   wr_addr_o,
  output swtb_pkg::entry_t   wr_data_o,
  input  swtb_pkg::entry_t   rdata_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output swtb_pkg::res_t     out_res_o,
  output logic               out_last_o
);

  localparam logic [IDX_W:0] NUM_LIM = (IDX_W + 1)'(NUM_TIMERS);

  swtb_pkg::ctrl_state_e state_q, state_d;
  swtb_pkg::cmd_e cmd_q, cmd_in;
  logic [3:0] idx_q;
  logic hh_q;
  logic [IDX_W:0] ptr_q;
  logic [IDX_W-1:0] s1_idx_q;
  logic pend_valid_q;
  swtb_pkg::res_t pend_q, pend_new;
  logic out_valid_q, out_last_q;
  swtb_pkg::res_t out_q;

  logic accept, idx_ok, out_free, is_done, nonzero, stall, ptr_more;
  logic pend_load, pend_clear, push, push_last;
  logic [IDX_W+3:0] wide_in, wide_q, wide_s1;
  logic [IDX_W-1:0] in_addr, idx_addr;

  assign cmd_in   = swtb_pkg::cmd_e'(in_cmd_i);
  assign accept   = in_valid_i && (state_q == swtb_pkg::ST_IDLE);
  assign wide_in  = {{IDX_W{1'b0}}, in_idx_i};
  assign wide_q   = {{IDX_W{1'b0}}, idx_q};
  assign wide_s1  = {4'd0, s1_idx_q};
  assign in_addr  = wide_in[IDX_W-1:0];
  assign idx_addr = wide_q[IDX_W-1:0];
  assign idx_ok   = {28'd0, idx_q} < 32'(NUM_TIMERS);
  assign out_free = !out_valid_q || out_ready_i;
  assign is_done  = rdata_i.st == swtb_pkg::TS_DONE;
  assign nonzero  = rdata_i.count != 32'd0;
  assign ptr_more = ptr_q < NUM_LIM;
  // A completed entry during service needs room in the pending stage.
  assign stall    = (state_q == swtb_pkg::ST_SWEEP) && (cmd_q == swtb_pkg::CMD_SERVICE)
                    && is_done && pend_valid_q && !out_free;

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      swtb_pkg::ST_IDLE: begin
        if (accept) begin
          case (cmd_in)
            swtb_pkg::CMD_TICK, swtb_pkg::CMD_SERVICE: state_d = swtb_pkg::ST_SWEEP;
            swtb_pkg::CMD_SET: state_d = swtb_pkg::ST_MUL;
            swtb_pkg::CMD_START, swtb_pkg::CMD_STOP, swtb_pkg::CMD_PAUSE,
            swtb_pkg::CMD_RESUME, swtb_pkg::CMD_CLEAR,
            swtb_pkg::CMD_READ: state_d = swtb_pkg::ST_ONE;
            default: state_d = swtb_pkg::ST_IDLE;
          endcase
        end
      end
      swtb_pkg::ST_MUL: state_d = swtb_pkg::ST_ONE;
      swtb_pkg::ST_ONE: state_d = swtb_pkg::ST_FLUSH;
      swtb_pkg::ST_SWEEP: begin
        if (!stall && !ptr_more) begin
          state_d = swtb_pkg::ST_FLUSH;
        end
      end
      swtb_pkg::ST_FLUSH: begin
        if (!pend_valid_q || out_free) begin
          state_d = swtb_pkg::ST_IDLE;
        end
      end
      default: state_d = swtb_pkg::ST_IDLE;
    endcase
  end

  // Memory controls and result staging per state.
  always_comb begin
    mem_ctl_o  = '0;
    rd_addr_o  = in_addr;
    wr_addr_o  = idx_addr;
    wr_data_o  = rdata_i;
    pend_load  = 1'b0;
    pend_clear = 1'b0;
    pend_new   = '0;
    push       = 1'b0;
    push_last  = 1'b1;
    case (state_q)
      swtb_pkg::ST_IDLE: begin
        if (accept) begin
          mem_ctl_o.rd_en = 1'b1;
          if (cmd_in == swtb_pkg::CMD_TICK || cmd_in == swtb_pkg::CMD_SERVICE) begin
            rd_addr_o = '0;
          end
          mem_ctl_o.clr_all = (cmd_in == swtb_pkg::CMD_CLEAR_ALL);
        end
      end
      swtb_pkg::ST_ONE: begin
        case (cmd_q)
          swtb_pkg::CMD_SET: begin
            mem_ctl_o.wr_en  = idx_ok;
            wr_data_o.count  = scaled_i;
            wr_data_o.notify = hh_q;
          end
          swtb_pkg::CMD_START: begin
            mem_ctl_o.wr_en = idx_ok && nonzero;
            wr_data_o.st    = swtb_pkg::TS_RUN;
          end
          swtb_pkg::CMD_STOP: mem_ctl_o.clr_one = idx_ok && nonzero;
          swtb_pkg::CMD_PAUSE: begin
            mem_ctl_o.wr_en = idx_ok && nonzero;
            wr_data_o.st    = swtb_pkg::TS_PAUSE;
          end
          swtb_pkg::CMD_RESUME: begin
            mem_ctl_o.wr_en = idx_ok && nonzero && (rdata_i.st == swtb_pkg::TS_PAUSE);
            wr_data_o.st    = swtb_pkg::TS_RUN;
          end
          swtb_pkg::CMD_CLEAR: mem_ctl_o.clr_one = idx_ok;
          swtb_pkg::CMD_READ: begin
            // An index beyond the bank reports an off timer.
            pend_load          = 1'b1;
            pend_new.which     = idx_q;
            pend_new.remaining = idx_ok ? rdata_i.count : 32'd0;
            pend_new.status    = idx_ok ? rdata_i.st : swtb_pkg::TS_OFF;
            pend_new.notify    = idx_ok && rdata_i.notify;
            pend_new.expired   = 1'b0;
          end
          default: ;
        endcase
      end
      swtb_pkg::ST_SWEEP: begin
        if (!stall) begin
          wr_addr_o = s1_idx_q;
          if (cmd_q == swtb_pkg::CMD_TICK) begin
            // A running timer at zero is left alone.
            mem_ctl_o.wr_en = (rdata_i.st == swtb_pkg::TS_RUN) && nonzero;
            wr_data_o.count = rdata_i.count - 32'd1;
            wr_data_o.st    = (rdata_i.count == 32'd1) ? swtb_pkg::TS_DONE
                                                       : swtb_pkg::TS_RUN;
          end else if (is_done) begin
            mem_ctl_o.clr_one  = 1'b1;
            pend_load          = 1'b1;
            pend_new.which     = wide_s1[3:0];
            pend_new.remaining = rdata_i.count;
            pend_new.status    = swtb_pkg::TS_DONE;
            pend_new.notify    = rdata_i.notify;
            pend_new.expired   = 1'b1;
            push               = pend_valid_q;
            push_last          = 1'b0;
          end
          if (ptr_more) begin
            mem_ctl_o.rd_en = 1'b1;
            rd_addr_o       = ptr_q[IDX_W-1:0];
          end
        end
      end
      swtb_pkg::ST_FLUSH: begin
        if (pend_valid_q && out_free) begin
          push       = 1'b1;
          pend_clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= swtb_pkg::ST_IDLE;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pend_load) begin
        pend_valid_q <= 1'b1;
      end else if (pend_clear) begin
        pend_valid_q <= 1'b0;
      end
      if (push) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Command, sweep pointer and result payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= cmd_in;
      idx_q    <= in_idx_i;
      hh_q     <= in_hh_i;
      ptr_q    <= (IDX_W + 1)'(1);
      s1_idx_q <= '0;
    end else if (state_q == swtb_pkg::ST_SWEEP && !stall && ptr_more) begin
      s1_idx_q <= ptr_q[IDX_W-1:0];
      ptr_q    <= ptr_q + (IDX_W + 1)'(1);
    end
    if (pend_load) begin
      pend_q <= pend_new;
    end
    if (push) begin
      out_q      <= pend_q;
      out_last_q <= push_last;
    end
  end

  assign in_ready_o  = state_q == swtb_pkg::ST_IDLE;
  assign load_o      = accept;
  assign out_valid_o = out_valid_q;
  assign out_res_o   = out_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== sv/software_timer_bank.sv =====
// Top level of the software timer bank.
`timescale 1ns / 1ps

// A bank of NUM_TIMERS countdown timers kept in one entry memory with a
// registered read. Each command word is handled alone: tick and service
// sweep the memory one entry per cycle, service only while no completed
// entry waits on a held-off result stream; set passes through two
// multiplier stages; start, stop, pause, resume, clear and read work on one
// entry, and a read waits while the result stream is held off; clear all
// and unknown commands go straight back to idle. Service emits one word per
// completed timer with tlast on the final one; read emits one word.
// The ticks-per-millisecond register is written through cfg_we_i; the user
// must write it only while the bank is idle, the bank does not enforce it.
module software_timer_bank #(
  parameter int NUM_TIMERS = swtb_pkg::NUM_TIMERS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [swtb_pkg::TPM_W-1:0] cfg_wdata_i,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [3:0] timer_index, [19:4] amount, [21:20] time_unit, [22] has_handler
  input  logic [23:0]                s_axis_tdata,
  // [3:0] cmd
  input  logic [3:0]                 s_axis_tuser,
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [3:0] which_timer, [35:4] remaining, [37:36] status, [38] notify
  output logic [39:0]                m_axis_tdata,
  // [0] expired
  output logic [0:0]                 m_axis_tuser,
  output logic                       m_axis_tlast
);

  localparam int IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

  swtb_pkg::mem_ctl_t mem_ctl;
  logic [IDX_W-1:0] rd_addr, wr_addr;
  swtb_pkg::entry_t wr_data, rdata;
  swtb_pkg::res_t res;
  logic load;
  logic [31:0] scaled;

  swtb_scale u_scale (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .load_i      (load),
    .amount_i    (s_axis_tdata[19:4]),
    .unit_i      (s_axis_tdata[21:20]),
    .scaled_o    (scaled)
  );

  swtb_mem #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (rd_addr),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rdata_o   (rdata)
  );

  swtb_ctrl #(
    .NUM_TIMERS (NUM_TIMERS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cmd_i    (s_axis_tuser),
    .in_idx_i    (s_axis_tdata[3:0]),
    .in_hh_i     (s_axis_tdata[22]),
    .scaled_i    (scaled),
    .load_o      (load),
    .mem_ctl_o   (mem_ctl),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rdata_i     (rdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_res_o   (res),
    .out_last_o  (m_axis_tlast)
  );

  // Pack the result word; the top pad bit is zero.
  assign m_axis_tdata = {1'b0, res.notify, res.status, res.remaining, res.which};
  assign m_axis_tuser = res.expired;

endmodule

// ===== sv/swtb_chk.sv =====
// Port-level checker for the software timer bank, bound to the top level.
`timescale 1ns / 1ps

module swtb_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata,
  input logic [0:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // A stalled result word holds still.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // While a service run is still delivering, no new command word is taken.
  a_busy_mid_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("command taken in the middle of a service run");

  // A read report is always a single, final word.
  a_read_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
    else $error("read report without tlast");

  // A service report always shows a completed timer.
  a_service_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[37:36] == swtb_pkg::TS_DONE)
    else $error("service report with status other than completed");

endmodule

bind software_timer_bank swtb_chk u_swtb_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
